/* rtl/pvp_pkg.sv */
// pvp_pkg: shared types and constants of the PES video packetizer
// no dependencies; used by the interfaces and every rtl module
package pvp_pkg;

  // command codes on the input channel
  localparam logic CMD_BEGIN = 1'b0;
  localparam logic CMD_BYTE  = 1'b1;

  // configuration register indexes
  localparam int unsigned CFG_INDEX_W = 1;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_PACKET = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_STREAM_ID  = 1'd1;

  // configuration reset values
  localparam logic [15:0] MAX_PACKET_RESET = 16'd2048;
  localparam logic [7:0]  STREAM_ID_RESET  = 8'hE0;

  // field widths
  localparam int unsigned LEN_W  = 24;
  localparam int unsigned PTS_W  = 33;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned PAY_W  = 16;

  // header bytes
  localparam logic [7:0] FLAGS_BYTE    = 8'h81;
  localparam logic [7:0] PTS_FLAG_BYTE = 8'h80;
  localparam logic [7:0] NO_FLAG_BYTE  = 8'h00;
  localparam logic [7:0] START_ZERO    = 8'h00;
  localparam logic [7:0] START_ONE     = 8'h01;
  localparam logic [3:0] PTS_PREFIX    = 4'h2;
  localparam logic [7:0] PTS_DATA_LEN  = 8'd5;

  // header sizes in bytes (count of bytes ahead of the payload)
  localparam logic [3:0] HDR_LEN_BASE = 4'd9;
  localparam logic [3:0] HDR_LEN_PTS  = 4'd14;
  // bytes counted by the packet length field ahead of the payload
  localparam logic [PAY_W-1:0] LEN_FIELD_BASE = 16'd3;

  // byte positions inside the header
  localparam logic [3:0] POS_START0   = 4'd0;
  localparam logic [3:0] POS_START1   = 4'd1;
  localparam logic [3:0] POS_START2   = 4'd2;
  localparam logic [3:0] POS_STREAM   = 4'd3;
  localparam logic [3:0] POS_LEN_HI   = 4'd4;
  localparam logic [3:0] POS_LEN_LO   = 4'd5;
  localparam logic [3:0] POS_FLAGS1   = 4'd6;
  localparam logic [3:0] POS_FLAGS2   = 4'd7;
  localparam logic [3:0] POS_HDR_LEN  = 4'd8;
  localparam logic [3:0] POS_PTS_TOP  = 4'd9;
  localparam logic [3:0] POS_PTS_MIDH = 4'd10;
  localparam logic [3:0] POS_PTS_MIDL = 4'd11;
  localparam logic [3:0] POS_PTS_LOH  = 4'd12;
  localparam logic [3:0] POS_PTS_LOL  = 4'd13;

  // queue depth default
  localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

  // one classified payload byte, as handed from front to back
  typedef struct packed {
    logic              hdr;       // byte opens a packet: header goes first
    logic              pts_on;    // header carries a PTS
    logic [PAY_W-1:0]  pay;       // payload bytes in this packet
    logic [PTS_W-1:0]  pts;       // timestamp for the header
    logic [BYTE_W-1:0] data;      // the payload byte
    logic              pkt_last;  // last payload byte of the packet
  } pvp_entry_t;

endpackage

/* rtl/pvp_if.sv */
// pvp_in_if and pvp_out_if: valid/ready channels of the packetizer
// depends on pvp_pkg for field widths
interface pvp_in_if import pvp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              command;
  logic [LEN_W-1:0]  payload_length;
  logic [PTS_W-1:0]  timestamp;
  logic [BYTE_W-1:0] payload_byte;

  modport source (output valid, command, payload_length, timestamp, payload_byte,
                  input ready);
  modport sink (input valid, command, payload_length, timestamp, payload_byte,
                output ready);
endinterface

interface pvp_out_if import pvp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              packet_end;
  logic              run_last;

  modport source (output valid, out_byte, packet_end, run_last, input ready);
  modport sink (input valid, out_byte, packet_end, run_last, output ready);
endinterface

/* rtl/pes_video_packetizer_core.sv */
// pes_video_packetizer_core: top level of the PES video packetizer
// depends on pvp_pkg, pvp_if, pvp_front, pvp_queue, pvp_back
//
//   channel  dir  transfer rule           payload
//   in_ch    in   valid && ready          command, payload_length, timestamp,
//                                         payload_byte
//   out_ch   out  valid && ready          out_byte, packet_end, run_last
//   cfg      in   cfg_we high at the edge cfg_index, cfg_data
//
// Payload bytes inside a packet pass at one per cycle while the output is
// not stalled, through the queue write and then the output register. The first
// byte of each packet follows a header of 9 bytes, or 14 with a PTS, since the
// back end emits one header byte per cycle while the output is not stalled; the
// queue of QUEUE_DEPTH entries keeps taking input meanwhile and ready falls once
// it is full. Begin items and dropped bytes take no queue entry, but they also
// wait while the queue is full. Reset sets max_packet_bytes to 2048, stream_id to
// 0xE0 and clears all counters; no clearing pass is needed.
module pes_video_packetizer_core import pvp_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  pvp_in_if.sink                 in_ch,
  pvp_out_if.source              out_ch
);

  logic [15:0] max_packet_bytes;
  logic [7:0]  stream_id;

  logic        push_valid;
  logic        push_ready;
  pvp_entry_t  push_entry;
  logic        pop_valid;
  logic        pop_ready;
  pvp_entry_t  pop_entry;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      max_packet_bytes <= MAX_PACKET_RESET;
      stream_id        <= STREAM_ID_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MAX_PACKET: max_packet_bytes <= cfg_data;
        REG_STREAM_ID:  stream_id        <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  pvp_front u_front (
    .clk              (clk),
    .rst              (rst),
    .in_ch            (in_ch),
    .max_packet_bytes (max_packet_bytes),
    .push_valid       (push_valid),
    .push_ready       (push_ready),
    .push_entry       (push_entry)
  );

  pvp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_entry  (pop_entry)
  );

  pvp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .stream_id (stream_id),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_entry (pop_entry),
    .out_ch    (out_ch)
  );

endmodule

/* rtl/pvp_front.sv */
// pvp_front: accepts input items, keeps payload and chunk counters,
// classifies each payload byte into a queue entry; depends on pvp_pkg
module pvp_front import pvp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  pvp_in_if.sink      in_ch,
  input  logic [15:0] max_packet_bytes,
  output logic        push_valid,
  input  logic        push_ready,
  output pvp_entry_t  push_entry
);

  logic [LEN_W-1:0] bytes_remaining;
  logic [PAY_W-1:0] chunk_remaining;
  logic [PTS_W-1:0] pts_value;
  logic             pts_present;

  logic             accept;
  logic             is_begin;
  logic             new_chunk;
  logic [PAY_W-1:0] hdr_total;
  logic [PAY_W-1:0] cap;
  logic [PAY_W-1:0] pay;
  logic [PAY_W-1:0] chunk_left;

  assign in_ch.ready = push_ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign is_begin    = (in_ch.command == CMD_BEGIN);

  // room for payload in a fresh packet, at least one byte
  always_comb begin
    hdr_total = pts_present ? PAY_W'(HDR_LEN_PTS) : PAY_W'(HDR_LEN_BASE);
    if (max_packet_bytes >= hdr_total + PAY_W'(1)) begin
      cap = max_packet_bytes - hdr_total;
    end else begin
      cap = PAY_W'(1);
    end
    if (bytes_remaining < {{(LEN_W-PAY_W){1'b0}}, cap}) begin
      pay = bytes_remaining[PAY_W-1:0];
    end else begin
      pay = cap;
    end
  end

  // classify a payload byte
  assign new_chunk  = (chunk_remaining == '0);
  assign chunk_left = (new_chunk ? pay : chunk_remaining) - PAY_W'(1);
  assign push_valid = in_ch.valid && !is_begin && (bytes_remaining != '0);

  always_comb begin
    push_entry.hdr      = new_chunk;
    push_entry.pts_on   = pts_present;
    push_entry.pay      = pay;
    push_entry.pts      = pts_value;
    push_entry.data     = in_ch.payload_byte;
    push_entry.pkt_last = (chunk_left == '0);
  end

  // payload state
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_remaining <= '0;
      chunk_remaining <= '0;
      pts_value       <= '0;
      pts_present     <= 1'b0;
    end else if (accept) begin
      if (is_begin) begin
        bytes_remaining <= in_ch.payload_length;
        pts_value       <= in_ch.timestamp;
        pts_present     <= (in_ch.timestamp != '0);
        chunk_remaining <= '0;
      end else if (bytes_remaining != '0) begin
        bytes_remaining <= bytes_remaining - LEN_W'(1);
        chunk_remaining <= chunk_left;
      end
    end
  end

  // a packet never holds more payload than is still expected
  a_chunk_within_payload: assert property (@(posedge clk) disable iff (rst)
    {{(LEN_W-PAY_W){1'b0}}, chunk_remaining} <= bytes_remaining)
    else $error("chunk counter exceeds remaining payload");

endmodule

/* rtl/pvp_queue.sv */
// pvp_queue: short queue of classified bytes between front and back
// depends on pvp_pkg for the entry type
module pvp_queue import pvp_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push_valid,
  output logic       push_ready,
  input  pvp_entry_t push_entry,
  output logic       pop_valid,
  input  logic       pop_ready,
  output pvp_entry_t pop_entry
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  pvp_entry_t       mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_entry  = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  // fill count rises by one on a push without a pop
  a_count_tracks: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + CNT_W'(1)))
    else $error("queue count lost a push");

endmodule

/* rtl/pvp_back.sv */
// pvp_back: serializes the header (with PTS when set) of a packet-opening entry
// and the payload byte of every queue entry into the output register; depends on pvp_pkg
module pvp_back import pvp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] stream_id,
  input  logic       pop_valid,
  output logic       pop_ready,
  input  pvp_entry_t pop_entry,
  pvp_out_if.source  out_ch
);

  logic [3:0]        step;
  logic              out_valid;
  logic [BYTE_W-1:0] out_byte;
  logic              out_end;
  logic              out_last;

  logic              emit;
  logic              is_payload;
  logic [3:0]        hdr_len;
  logic [PAY_W-1:0]  total;
  logic [15:0]       pts_mid;
  logic [15:0]       pts_lo;
  logic [BYTE_W-1:0] hdr_byte;

  assign hdr_len    = pop_entry.pts_on ? HDR_LEN_PTS : HDR_LEN_BASE;
  assign is_payload = !pop_entry.hdr || (step == hdr_len);
  assign emit       = pop_valid && (!out_valid || out_ch.ready);
  assign pop_ready  = emit && is_payload;

  // packet length field and PTS words
  assign total   = pop_entry.pay + LEN_FIELD_BASE
                 + (pop_entry.pts_on ? PAY_W'(PTS_DATA_LEN) : PAY_W'(0));
  assign pts_mid = {pop_entry.pts[29:15], 1'b1};
  assign pts_lo  = {pop_entry.pts[14:0], 1'b1};

  // header byte select
  always_comb begin
    unique case (step)
      POS_START0:   hdr_byte = START_ZERO;
      POS_START1:   hdr_byte = START_ZERO;
      POS_START2:   hdr_byte = START_ONE;
      POS_STREAM:   hdr_byte = stream_id;
      POS_LEN_HI:   hdr_byte = total[15:8];
      POS_LEN_LO:   hdr_byte = total[7:0];
      POS_FLAGS1:   hdr_byte = FLAGS_BYTE;
      POS_FLAGS2:   hdr_byte = pop_entry.pts_on ? PTS_FLAG_BYTE : NO_FLAG_BYTE;
      POS_HDR_LEN:  hdr_byte = pop_entry.pts_on ? PTS_DATA_LEN : 8'd0;
      POS_PTS_TOP:  hdr_byte = {PTS_PREFIX, pop_entry.pts[32:30], 1'b1};
      POS_PTS_MIDH: hdr_byte = pts_mid[15:8];
      POS_PTS_MIDL: hdr_byte = pts_mid[7:0];
      POS_PTS_LOH:  hdr_byte = pts_lo[15:8];
      POS_PTS_LOL:  hdr_byte = pts_lo[7:0];
      default:      hdr_byte = 8'd0;
    endcase
  end

  // step counter through the header of the head entry
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
    end else if (emit) begin
      step <= is_payload ? 4'd0 : step + 4'd1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte <= is_payload ? pop_entry.data : hdr_byte;
      out_end  <= is_payload && pop_entry.pkt_last;
      out_last <= is_payload;
    end
  end

  assign out_ch.valid      = out_valid;
  assign out_ch.out_byte   = out_byte;
  assign out_ch.packet_end = out_end;
  assign out_ch.run_last   = out_last;

  // header steps stay inside the head entry's header
  a_step_in_header: assert property (@(posedge clk) disable iff (rst)
    pop_valid |-> (step <= hdr_len) && (pop_entry.hdr || step == 4'd0))
    else $error("header step out of range");

  // a packet only ends on a payload byte
  a_end_on_payload: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_end) |-> out_last)
    else $error("packet end on a header byte");

endmodule
